/* sv/vbsr_pkg.sv */
// Shared constants, codes and types of the video bitstream syntax reader.
package vbsr_pkg;

  // Byte store geometry
  localparam int BUF_BYTES = 4096;
  localparam int ADDR_W    = $clog2(BUF_BYTES);
  localparam int LEN_W     = $clog2(BUF_BYTES + 1);

  // Command codes
  localparam logic [3:0] CMD_LOAD = 4'd0;
  localparam logic [3:0] CMD_BITS = 4'd1;
  localparam logic [3:0] CMD_UE   = 4'd2;
  localparam logic [3:0] CMD_SE   = 4'd3;
  localparam logic [3:0] CMD_UVLC = 4'd4;
  localparam logic [3:0] CMD_LEB  = 4'd5;
  localparam logic [3:0] CMD_NS   = 4'd6;
  localparam logic [3:0] CMD_SU   = 4'd7;
  localparam logic [3:0] CMD_MORE = 4'd8;

  // Status codes
  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_END = 2'd1;
  localparam logic [1:0] STAT_ARG = 2'd2;

  // Byte store port: one write and one registered read per cycle
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } store_req_t;

  // One finished result
  typedef struct packed {
    logic [63:0] value;
    logic [15:0] bits_used;
    logic [1:0]  status;
    logic        more_data;
  } result_t;

endpackage

/* sv/vbsr_req_if.sv */
// Request channel: load and read commands with their arguments.
interface vbsr_req_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [6:0]  bit_count_req;
  logic [31:0] max_value;

  modport source (
    output valid, cmd, data_byte, first_byte, bit_count_req, max_value,
    input  ready
  );
  modport sink (
    input  valid, cmd, data_byte, first_byte, bit_count_req, max_value,
    output ready
  );
endinterface

/* sv/vbsr_res_if.sv */
// Result channel: decoded element, consumed bit count, status and query answer.
interface vbsr_res_if;
  logic        valid;
  logic        ready;
  logic [63:0] value;
  logic [15:0] bits_used;
  logic [1:0]  status;
  logic        more_data;

  modport source (
    output valid, value, bits_used, status, more_data,
    input  ready
  );
  modport sink (
    input  valid, value, bits_used, status, more_data,
    output ready
  );
endinterface

/* sv/video_bitstream_syntax_reader.sv */
// Top level of the video bitstream syntax reader.
//
// Requests arrive on req (valid/ready). A load request (cmd 0) writes one byte
// into the byte store (dropped when full and first_byte is clear) and gives
// no result; first_byte set empties the store and restarts the read position.
// Every other command gives exactly one result on res (valid/ready): value,
// bits_used, status and more_data. cfg_we_i writes cfg_wdata_i into the
// emulation prevention switch. Reads walk the store one bit per cycle through
// a shared bit sequencer, pausing when the current byte must be fetched first
// and at each byte boundary, where with emulation prevention on a 0x03 after
// two zero bytes is dropped. A request is accepted, worked and handed over;
// final arithmetic follows for ue, se, a short uvlc and ns. ns first finds the
// bit length of its alphabet size, one shift at a time, and leb128 ends by
// aligning its groups. The more-data query scans backward from the end of the
// store, one byte visited at a time. One request is in work at a time; req is
// ready only between requests. Reset empties the store, clears the read
// position and turns emulation prevention on. A finished result waits in an
// output register; while the receiver stalls, the next request can still be
// taken and worked on, and it holds at completion until the output register
// is free.
module video_bitstream_syntax_reader import vbsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  vbsr_req_if.sink   req,
  vbsr_res_if.source res
);

  store_req_t store_req;
  logic [7:0] store_rdata;
  logic       core_valid;
  logic       core_ready;
  result_t    core_res;

  vbsr_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  vbsr_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req           (req),
    .store_o       (store_req),
    .store_rdata_i (store_rdata),
    .res_valid_o   (core_valid),
    .res_ready_i   (core_ready),
    .res_o         (core_res)
  );

  vbsr_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (core_valid),
    .res_ready_o (core_ready),
    .res_i       (core_res),
    .res         (res)
  );

endmodule

/* sv/vbsr_store.sv */
// Byte store: single write port and one registered read port.
module vbsr_store import vbsr_pkg::*; (
  input  logic       clk_i,
  input  store_req_t req_i,
  output logic [7:0] rdata_o
);

  logic [7:0] mem_q [BUF_BYTES];
  logic [7:0] rdata_q;

  // Write on load, read the addressed byte every cycle
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/vbsr_core.sv */
// Bit-serial parse sequencer: walks the byte store one bit per cycle, pausing to fetch and step over bytes.
module vbsr_core import vbsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  vbsr_req_if.sink   req,
  output store_req_t store_o,
  input  logic [7:0] store_rdata_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);

  // Sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BIT   = 4'd1;
  localparam logic [3:0] S_FETCH = 4'd2;
  localparam logic [3:0] S_NB    = 4'd3;
  localparam logic [3:0] S_EM    = 4'd4;
  localparam logic [3:0] S_NSW   = 4'd5;
  localparam logic [3:0] S_NSM   = 4'd6;
  localparam logic [3:0] S_NSC   = 4'd7;
  localparam logic [3:0] S_NSF   = 4'd8;
  localparam logic [3:0] S_FIX   = 4'd9;
  localparam logic [3:0] S_SE    = 4'd10;
  localparam logic [3:0] S_ALIGN = 4'd11;
  localparam logic [3:0] S_SCAN  = 4'd12;
  localparam logic [3:0] S_SCAN2 = 4'd13;
  localparam logic [3:0] S_DONE  = 4'd14;

  // What a taken bit is used for
  localparam logic [2:0] PH_FIX  = 3'd0;
  localparam logic [2:0] PH_ZERO = 3'd1;
  localparam logic [2:0] PH_SUF  = 3'd2;
  localparam logic [2:0] PH_LEB  = 3'd3;
  localparam logic [2:0] PH_NSX  = 3'd4;

  logic [3:0]       state_q, state_d, ret_q, ret_d;
  logic [2:0]       ph_q, ph_d;
  logic [3:0]       cmd_q, cmd_d;
  logic             sx_q, sx_d, first_q, first_d;
  logic [63:0]      acc_q, acc_d;
  logic [6:0]       rem_q, rem_d;
  logic [15:0]      used_q, used_d;
  logic [1:0]       stat_q, stat_d;
  logic             more_q, more_d;
  logic [LEN_W-1:0] len_q, len_d, bp_q, bp_d, sv_bp_q, sv_bp_d;
  logic [3:0]       bitp_q, bitp_d, sv_bitp_q, sv_bitp_d;
  logic [1:0]       zr_q, zr_d, sv_zr_q, sv_zr_d;
  logic [7:0]       cur_q, cur_d;
  logic             cur_ok_q, cur_ok_d;
  logic             skip_q, skip_d;
  logic [31:0]      m_q, m_d, x_q, x_d;
  logic [5:0]       w_q, w_d;
  logic [2:0]       bi_q, bi_d, lb_q, lb_d;
  logic             cont_q, cont_d;
  logic [5:0]       grp_q, grp_d;
  logic [LEN_W-1:0] scan_q, scan_d;

  logic             bit_w;
  logic [LEN_W-1:0] bp_inc, scan_m1;
  logic [LEN_W+3:0] cur_pos, last_pos;
  logic [63:0]      half;

  // Position of the lowest set bit, counted from the MSB
  function automatic logic [2:0] last_one(input logic [7:0] b);
    logic [2:0] k;
    k = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        k = 3'(7 - i);
      end
    end
    return k;
  endfunction

  assign bit_w    = cur_q[~bitp_q[2:0]];
  assign bp_inc   = bp_q + 1'b1;
  assign scan_m1  = scan_q - 1'b1;
  assign cur_pos  = {1'b0, bp_q, 3'b000} + {{LEN_W{1'b0}}, bitp_q};
  assign last_pos = {1'b0, scan_m1, last_one(store_rdata_i)};
  assign half     = {1'b0, acc_q[63:1]};

  assign req.ready = (state_q == S_IDLE);

  // Result fields; a failed request reports zero value and no bits
  assign res_o.value     = (stat_q == STAT_OK) ? acc_q : 64'd0;
  assign res_o.bits_used = (stat_q == STAT_OK) ? used_q : 16'd0;
  assign res_o.status    = stat_q;
  assign res_o.more_data = more_q;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    ret_d     = ret_q;
    ph_d      = ph_q;
    cmd_d     = cmd_q;
    sx_d      = sx_q;
    first_d   = first_q;
    acc_d     = acc_q;
    rem_d     = rem_q;
    used_d    = used_q;
    stat_d    = stat_q;
    more_d    = more_q;
    len_d     = len_q;
    bp_d      = bp_q;
    bitp_d    = bitp_q;
    zr_d      = zr_q;
    sv_bp_d   = sv_bp_q;
    sv_bitp_d = sv_bitp_q;
    sv_zr_d   = sv_zr_q;
    cur_d     = cur_q;
    cur_ok_d  = cur_ok_q;
    skip_d    = skip_q;
    m_d       = m_q;
    x_d       = x_q;
    w_d       = w_q;
    bi_d      = bi_q;
    lb_d      = lb_q;
    cont_d    = cont_q;
    grp_d     = grp_q;
    scan_d    = scan_q;

    store_o.we    = 1'b0;
    store_o.waddr = len_q[ADDR_W-1:0];
    store_o.wdata = req.data_byte;
    store_o.raddr = bp_q[ADDR_W-1:0];
    res_valid_o   = 1'b0;

    if (cfg_we_i) begin
      skip_d = cfg_wdata_i;
    end

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          cmd_d     = req.cmd;
          sv_bp_d   = bp_q;
          sv_bitp_d = bitp_q;
          sv_zr_d   = zr_q;
          used_d    = 16'd0;
          acc_d     = 64'd0;
          first_d   = 1'b1;
          sx_d      = 1'b0;
          more_d    = 1'b0;
          stat_d    = STAT_OK;
          case (req.cmd)
            CMD_LOAD: begin
              // Append a byte; a first byte restarts the store
              if (req.first_byte) begin
                store_o.we    = 1'b1;
                store_o.waddr = '0;
                len_d         = LEN_W'(1);
                bp_d          = '0;
                bitp_d        = 4'd0;
                zr_d          = 2'd0;
                cur_ok_d      = 1'b0;
              end else if (len_q < LEN_W'(BUF_BYTES)) begin
                store_o.we = 1'b1;
                len_d      = len_q + 1'b1;
              end
            end
            CMD_BITS, CMD_SU: begin
              if (req.bit_count_req > 7'd64) begin
                stat_d  = STAT_ARG;
                state_d = S_DONE;
              end else if (req.bit_count_req == 7'd0) begin
                state_d = S_DONE;
              end else begin
                ph_d    = PH_FIX;
                rem_d   = req.bit_count_req;
                sx_d    = (req.cmd == CMD_SU);
                state_d = S_BIT;
              end
            end
            CMD_UE, CMD_SE, CMD_UVLC: begin
              ph_d    = PH_ZERO;
              rem_d   = 7'd0;
              state_d = S_BIT;
            end
            CMD_LEB: begin
              ph_d    = PH_LEB;
              bi_d    = 3'd0;
              lb_d    = 3'd0;
              state_d = S_BIT;
            end
            CMD_NS: begin
              if (req.max_value == 32'd0) begin
                stat_d  = STAT_ARG;
                state_d = S_DONE;
              end else begin
                m_d     = req.max_value;
                x_d     = req.max_value;
                w_d     = 6'd32;
                state_d = S_NSW;
              end
            end
            CMD_MORE: begin
              scan_d  = len_q;
              state_d = S_SCAN;
            end
            default: begin
              stat_d  = STAT_ARG;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_BIT: begin
        if (bitp_q[3]) begin
          state_d = S_NB;
        end else if (bp_q >= len_q) begin
          stat_d  = STAT_END;
          state_d = S_DONE;
        end else if (!cur_ok_q) begin
          ret_d   = S_BIT;
          state_d = S_FETCH;
        end else begin
          // Take one bit and advance
          bitp_d = bitp_q + 4'd1;
          used_d = used_q + 16'd1;
          case (ph_q)
            PH_FIX: begin
              acc_d   = (first_q && sx_q) ? {64{bit_w}} : {acc_q[62:0], bit_w};
              first_d = 1'b0;
              rem_d   = rem_q - 7'd1;
              if (rem_q == 7'd1) begin
                state_d = (cmd_q == CMD_NS) ? S_NSC : S_DONE;
              end
            end
            PH_ZERO: begin
              if (!bit_w) begin
                if (cmd_q == CMD_UVLC) begin
                  if (rem_q != 7'd32) begin
                    rem_d = rem_q + 7'd1;
                  end
                end else if (rem_q == 7'd63) begin
                  stat_d  = STAT_ARG;
                  state_d = S_DONE;
                end else begin
                  rem_d = rem_q + 7'd1;
                end
              end else if (cmd_q == CMD_UVLC && rem_q[5]) begin
                // 32 or more leading zeros saturate
                acc_d   = 64'h0000_0000_FFFF_FFFF;
                state_d = S_DONE;
              end else begin
                // Leading one seeds the suffix; value is this minus one
                acc_d = 64'd1;
                if (rem_q == 7'd0) begin
                  state_d = S_FIX;
                end else begin
                  ph_d = PH_SUF;
                end
              end
            end
            PH_SUF: begin
              acc_d = {acc_q[62:0], bit_w};
              rem_d = rem_q - 7'd1;
              if (rem_q == 7'd1) begin
                state_d = S_FIX;
              end
            end
            PH_LEB: begin
              bi_d = bi_q + 3'd1;
              if (bi_q == 3'd0) begin
                cont_d = bit_w;
              end else if (bi_q != 3'd7) begin
                grp_d = {grp_q[4:0], bit_w};
              end else begin
                // Insert the group at the top, older groups move down
                acc_d = {8'h00, grp_q, bit_w, acc_q[55:7]};
                if (!cont_q || lb_q == 3'd7) begin
                  rem_d   = {4'd0, 3'd7 - lb_q};
                  state_d = (lb_q == 3'd7) ? S_DONE : S_ALIGN;
                end else begin
                  lb_d = lb_q + 3'd1;
                end
              end
            end
            PH_NSX: begin
              acc_d   = {acc_q[62:0], bit_w};
              state_d = S_NSF;
            end
            default: begin
              stat_d  = STAT_ARG;
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_FETCH: begin
        cur_d    = store_rdata_i;
        cur_ok_d = 1'b1;
        state_d  = ret_q;
      end

      S_NB: begin
        // Step onto the next byte, tracking zero bytes left behind
        if (bp_q >= len_q) begin
          stat_d  = STAT_END;
          state_d = S_DONE;
        end else if (!cur_ok_q) begin
          ret_d   = S_NB;
          state_d = S_FETCH;
        end else begin
          if (cur_q == 8'h00 && zr_q != 2'd3) begin
            zr_d = zr_q + 2'd1;
          end
          bitp_d   = 4'd0;
          bp_d     = bp_inc;
          cur_ok_d = 1'b0;
          if (bp_inc >= len_q) begin
            stat_d  = STAT_END;
            state_d = S_DONE;
          end else begin
            state_d = skip_q ? S_EM : S_BIT;
          end
        end
      end

      S_EM: begin
        // Drop an emulation prevention byte after two zero bytes
        if (!cur_ok_q) begin
          ret_d   = S_EM;
          state_d = S_FETCH;
        end else if (zr_q == 2'd2 && cur_q == 8'h03) begin
          bp_d     = bp_inc;
          cur_ok_d = 1'b0;
          if (bp_inc >= len_q) begin
            stat_d  = STAT_END;
            state_d = S_DONE;
          end else begin
            zr_d    = 2'd0;
            state_d = S_BIT;
          end
        end else begin
          if (cur_q != 8'h00) begin
            zr_d = 2'd0;
          end
          state_d = S_BIT;
        end
      end

      S_NSW: begin
        // Find the bit length of the alphabet size, one shift a cycle
        if (x_q[31]) begin
          state_d = S_NSM;
        end else begin
          x_d = {x_q[30:0], 1'b0};
          w_d = w_q - 6'd1;
        end
      end

      S_NSM: begin
        m_d   = 32'((33'd1 << w_q) - {1'b0, m_q});
        rem_d = {1'b0, w_q - 6'd1};
        if (w_q == 6'd1) begin
          state_d = S_NSC;
        end else begin
          ph_d    = PH_FIX;
          state_d = S_BIT;
        end
      end

      S_NSC: begin
        if (acc_q[31:0] < m_q) begin
          state_d = S_DONE;
        end else begin
          ph_d    = PH_NSX;
          state_d = S_BIT;
        end
      end

      S_NSF: begin
        acc_d   = acc_q - {32'd0, m_q};
        state_d = S_DONE;
      end

      S_FIX: begin
        acc_d   = acc_q - 64'd1;
        state_d = (cmd_q == CMD_SE) ? S_SE : S_DONE;
      end

      S_SE: begin
        acc_d   = acc_q[0] ? half + 64'd1 : 64'd0 - half;
        state_d = S_DONE;
      end

      S_ALIGN: begin
        // Move the leb128 groups down to bit zero, one group a cycle
        acc_d = {15'd0, acc_q[55:7]};
        rem_d = rem_q - 7'd1;
        if (rem_q == 7'd1) begin
          state_d = S_DONE;
        end
      end

      S_SCAN: begin
        // Walk back from the end looking for the last nonzero byte
        if (scan_q == '0) begin
          state_d = S_DONE;
        end else begin
          store_o.raddr = scan_m1[ADDR_W-1:0];
          state_d       = S_SCAN2;
        end
      end

      S_SCAN2: begin
        if (store_rdata_i != 8'h00) begin
          more_d  = (last_pos > cur_pos);
          state_d = S_DONE;
        end else begin
          scan_d  = scan_m1;
          state_d = S_SCAN;
        end
      end

      S_DONE: begin
        // Hand over the result; a failed request leaves the position as it was
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          if (stat_q != STAT_OK) begin
            bp_d     = sv_bp_q;
            bitp_d   = sv_bitp_q;
            zr_d     = sv_zr_q;
            cur_ok_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      ret_q     <= S_IDLE;
      ph_q      <= PH_FIX;
      cmd_q     <= CMD_LOAD;
      sx_q      <= 1'b0;
      first_q   <= 1'b0;
      acc_q     <= 64'd0;
      rem_q     <= 7'd0;
      used_q    <= 16'd0;
      stat_q    <= STAT_OK;
      more_q    <= 1'b0;
      len_q     <= '0;
      bp_q      <= '0;
      bitp_q    <= 4'd0;
      zr_q      <= 2'd0;
      sv_bp_q   <= '0;
      sv_bitp_q <= 4'd0;
      sv_zr_q   <= 2'd0;
      cur_q     <= 8'h00;
      cur_ok_q  <= 1'b0;
      skip_q    <= 1'b1;
      m_q       <= 32'd0;
      x_q       <= 32'd0;
      w_q       <= 6'd0;
      bi_q      <= 3'd0;
      lb_q      <= 3'd0;
      cont_q    <= 1'b0;
      grp_q     <= 6'd0;
      scan_q    <= '0;
    end else begin
      state_q   <= state_d;
      ret_q     <= ret_d;
      ph_q      <= ph_d;
      cmd_q     <= cmd_d;
      sx_q      <= sx_d;
      first_q   <= first_d;
      acc_q     <= acc_d;
      rem_q     <= rem_d;
      used_q    <= used_d;
      stat_q    <= stat_d;
      more_q    <= more_d;
      len_q     <= len_d;
      bp_q      <= bp_d;
      bitp_q    <= bitp_d;
      zr_q      <= zr_d;
      sv_bp_q   <= sv_bp_d;
      sv_bitp_q <= sv_bitp_d;
      sv_zr_q   <= sv_zr_d;
      cur_q     <= cur_d;
      cur_ok_q  <= cur_ok_d;
      skip_q    <= skip_d;
      m_q       <= m_d;
      x_q       <= x_d;
      w_q       <= w_d;
      bi_q      <= bi_d;
      lb_q      <= lb_d;
      cont_q    <= cont_d;
      grp_q     <= grp_d;
      scan_q    <= scan_d;
    end
  end

endmodule

/* sv/vbsr_out.sv */
// Output register between the sequencer and the result channel.
module vbsr_out import vbsr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       res_valid_i,
  output logic       res_ready_o,
  input  result_t    res_i,
  vbsr_res_if.source res
);

  logic    valid_q;
  result_t data_q;

  assign res_ready_o = !valid_q || res.ready;

  // Load a new result when free or being drained, else drop valid once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      data_q  <= '0;
    end else if (res_valid_i && res_ready_o) begin
      valid_q <= 1'b1;
      data_q  <= res_i;
    end else if (res.ready) begin
      valid_q <= 1'b0;
    end
  end

  assign res.valid     = valid_q;
  assign res.value     = data_q.value;
  assign res.bits_used = data_q.bits_used;
  assign res.status    = data_q.status;
  assign res.more_data = data_q.more_data;

endmodule

/* test/tb.sv */
// Self-checking testbench for the video bitstream syntax reader: directed and random requests.
module tb;
  import vbsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 40;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 380;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  vbsr_req_if req_ch ();
  vbsr_res_if res_ch ();

  video_bitstream_syntax_reader DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req         (req_ch),
    .res         (res_ch)
  );

  // Predictor state: shadow byte store, read position and emulation switch
  logic [7:0]  byte_mem [BUF_BYTES];
  int unsigned mem_len;
  int unsigned rd_byte;
  int unsigned rd_bit;
  int unsigned zeros_seen;
  int unsigned bit_tally;
  logic        epb_on;

  result_t     expected_elems [$];
  int unsigned mismatch_count;
  int unsigned sent_items;
  int unsigned send_gap_pct;
  int unsigned recv_gap_pct;
  int unsigned stall_left;

  // Byte at index i, zero past the stored length
  function automatic logic [7:0] mem_at(int unsigned i);
    if (i >= mem_len) return 8'h00;
    return byte_mem[i];
  endfunction

  // Step onto the next byte, dropping an emulation prevention byte when the switch is on
  function automatic bit step_byte();
    if (rd_byte >= mem_len) return 1'b0;
    if (mem_at(rd_byte) == 8'h00 && zeros_seen < 3) zeros_seen++;
    rd_bit = 0;
    rd_byte++;
    if (rd_byte >= mem_len) return 1'b0;
    if (epb_on) begin
      if (zeros_seen == 2 && mem_at(rd_byte) == 8'h03) begin
        rd_byte++;
        if (rd_byte >= mem_len) return 1'b0;
        zeros_seen = 0;
      end else if (mem_at(rd_byte) != 8'h00) begin
        zeros_seen = 0;
      end
    end
    return 1'b1;
  endfunction

  // Pull n bits MSB-first
  function automatic logic [1:0] pull_bits(int unsigned n, output logic [63:0] v);
    logic [63:0] acc;
    logic [7:0]  cur;
    acc = '0;
    v   = '0;
    for (int unsigned k = 0; k < n; k++) begin
      if (rd_bit >= 8 && !step_byte()) return STAT_END;
      if (rd_byte >= mem_len) return STAT_END;
      cur = mem_at(rd_byte);
      acc = {acc[62:0], cur[7 - rd_bit]};
      rd_bit++;
      bit_tally++;
    end
    v = acc;
    return STAT_OK;
  endfunction

  // Count leading zeros up to the terminating one bit
  function automatic logic [1:0] zero_prefix(longint unsigned limit, output int unsigned z);
    logic [63:0] b;
    logic [1:0]  st;
    int unsigned cnt;
    cnt = 0;
    z   = 0;
    forever begin
      st = pull_bits(1, b);
      if (st != STAT_OK) return st;
      if (b[0]) break;
      cnt++;
      if (cnt >= limit) return STAT_ARG;
    end
    z = cnt;
    return STAT_OK;
  endfunction

  // Unsigned Exp-Golomb code
  function automatic logic [1:0] golomb(output logic [63:0] v);
    int unsigned z;
    logic [63:0] s;
    logic [1:0]  st;
    v  = '0;
    st = zero_prefix(64, z);
    if (st != STAT_OK) return st;
    st = pull_bits(z, s);
    if (st != STAT_OK) return st;
    v = s + ((64'd1 << z) - 64'd1);
    return STAT_OK;
  endfunction

  // True when the last set bit of the store lies after the read position
  function automatic logic payload_left();
    int unsigned pos;
    int unsigned k;
    logic [7:0]  c;
    pos = rd_byte * 8 + rd_bit;
    for (int i = int'(mem_len) - 1; i >= 0; i--) begin
      c = mem_at(i);
      if (c != 8'h00) begin
        k = 7;
        while (c[0] == 1'b0) begin
          c = c >> 1;
          k--;
        end
        return (i * 8 + k) > pos;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow state and queue its expected element
  function automatic void predict_element(logic [3:0] cmd, logic [7:0] data, logic first,
                                          logic [6:0] n, logic [31:0] maxv);
    int unsigned sv_byte, sv_bit, sv_zero, z, w;
    logic [1:0]  st;
    logic [63:0] val, b, v, extra, m;
    logic [31:0] x;
    logic        more;
    result_t     r;
    sv_byte = rd_byte;
    sv_bit  = rd_bit;
    sv_zero = zeros_seen;
    st      = STAT_OK;
    val     = '0;
    more    = 1'b0;
    if (cmd == CMD_LOAD) begin
      if (first) begin
        mem_len    = 0;
        rd_byte    = 0;
        rd_bit     = 0;
        zeros_seen = 0;
      end
      if (mem_len < BUF_BYTES) begin
        byte_mem[mem_len] = data;
        mem_len++;
      end
      return;
    end
    bit_tally = 0;
    case (cmd)
      CMD_BITS: begin
        if (n > 64) st = STAT_ARG;
        else st = pull_bits(n, val);
      end
      CMD_UE: st = golomb(val);
      CMD_SE: begin
        st = golomb(val);
        if (st == STAT_OK) val = val[0] ? (val >> 1) + 64'd1 : 64'd0 - (val >> 1);
      end
      CMD_UVLC: begin
        st = zero_prefix(64'hFFFF_FFFF, z);
        if (st == STAT_OK) begin
          if (z >= 32) begin
            val = 64'hFFFF_FFFF;
          end else begin
            st  = pull_bits(z, val);
            val = val + ((64'd1 << z) - 64'd1);
          end
        end
      end
      CMD_LEB: begin
        for (int unsigned i = 0; i < 8; i++) begin
          st = pull_bits(8, b);
          if (st != STAT_OK) break;
          val = val | ((b & 64'h7F) << (i * 7));
          if (!b[7]) break;
        end
      end
      CMD_NS: begin
        if (maxv == 32'd0) begin
          st = STAT_ARG;
        end else begin
          x = maxv;
          w = 0;
          while (x != 32'd0) begin
            x = x >> 1;
            w++;
          end
          m  = (64'd1 << w) - {32'd0, maxv};
          st = pull_bits(w - 1, v);
          if (st == STAT_OK) begin
            if (v < m) begin
              val = v;
            end else begin
              st  = pull_bits(1, extra);
              val = (v << 1) - m + extra;
            end
          end
        end
      end
      CMD_SU: begin
        if (n > 64) begin
          st = STAT_ARG;
        end else begin
          st = pull_bits(n, val);
          if (st == STAT_OK && n > 0 && n < 64 && val[n - 1]) val = val | (~64'd0 << n);
        end
      end
      CMD_MORE: more = payload_left();
      default: st = STAT_ARG;
    endcase
    // Failed requests leave the read position untouched
    if (st != STAT_OK) begin
      rd_byte    = sv_byte;
      rd_bit     = sv_bit;
      zeros_seen = sv_zero;
      val        = '0;
      bit_tally  = 0;
    end
    r.value     = val;
    r.bits_used = bit_tally[15:0];
    r.status    = st;
    r.more_data = more;
    expected_elems.push_back(r);
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Drive the result ready: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Compare each accepted result with the oldest expected element
  always @(posedge clk_i) begin
    result_t want;
    result_t got;
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      got.value     = res_ch.value;
      got.bits_used = res_ch.bits_used;
      got.status    = res_ch.status;
      got.more_data = res_ch.more_data;
      if (expected_elems.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected result: value=%h bits=%0d status=%0d more=%0d",
                   got.value, got.bits_used, got.status, got.more_data);
      end else begin
        want = expected_elems.pop_front();
        if (got.value !== want.value || got.bits_used !== want.bits_used ||
            got.status !== want.status || got.more_data !== want.more_data) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     want.value, want.bits_used, want.status, want.more_data,
                     got.value, got.bits_used, got.status, got.more_data);
        end
      end
    end
  end

  // Offer one request and hold it until accepted
  task automatic send_req(logic [3:0] cmd, logic [7:0] data, logic first,
                          logic [6:0] n, logic [31:0] maxv);
    @(negedge clk_i);
    while ($urandom_range(99) < send_gap_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid         <= 1'b1;
    req_ch.cmd           <= cmd;
    req_ch.data_byte     <= data;
    req_ch.first_byte    <= first;
    req_ch.bit_count_req <= n;
    req_ch.max_value     <= maxv;
    do begin
      @(posedge clk_i);
    end while (!req_ch.ready);
    predict_element(cmd, data, first, n, maxv);
    sent_items++;
  endtask

  task automatic load_byte(logic [7:0] data, logic first);
    send_req(CMD_LOAD, data, first, 7'($urandom), $urandom);
  endtask

  task automatic read_elem(logic [3:0] cmd, logic [6:0] n, logic [31:0] maxv);
    send_req(cmd, 8'($urandom), 1'($urandom), n, maxv);
  endtask

  // Load a whole stream, restarting the store with its first byte
  task automatic load_stream(logic [7:0] bytes [$]);
    foreach (bytes[i]) load_byte(bytes[i], i == 0);
  endtask

  // Drop valid, wait for every expected element, then let the block settle
  task automatic drain_results();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (expected_elems.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write the emulation prevention switch while idle
  task automatic set_epb(logic v);
    drain_results();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    epb_on = v;
  endtask

  // Every command, field extremes, bad arguments and reads past the end
  task automatic test_command_set();
    load_stream('{8'hFF, 8'h00, 8'h00, 8'h03, 8'h81, 8'h7F, 8'h80, 8'h01,
                  8'hC3, 8'h5A, 8'hA5, 8'h3C, 8'h96, 8'hE1});
    read_elem(CMD_BITS, 7'd0, 32'd0);
    read_elem(CMD_SU, 7'd0, 32'd0);
    read_elem(CMD_BITS, 7'd64, 32'd0);
    read_elem(CMD_BITS, 7'd65, 32'd0);
    read_elem(CMD_SU, 7'd127, 32'd0);
    read_elem(CMD_SU, 7'd7, 32'd0);
    read_elem(CMD_UE, 7'd0, 32'd0);
    read_elem(CMD_SE, 7'd0, 32'd0);
    read_elem(CMD_UVLC, 7'd0, 32'd0);
    read_elem(CMD_LEB, 7'd0, 32'd0);
    read_elem(CMD_NS, 7'd0, 32'd0);
    read_elem(CMD_NS, 7'd0, 32'd5);
    read_elem(CMD_MORE, 7'd0, 32'd0);
    read_elem(4'd9, 7'd0, 32'd0);
    read_elem(4'd15, 7'd127, 32'hFFFF_FFFF);
    read_elem(CMD_NS, 7'd0, 32'hFFFF_FFFF);
    read_elem(CMD_SU, 7'd64, 32'd0);
    read_elem(CMD_BITS, 7'd64, 32'd0);
    read_elem(CMD_MORE, 7'd0, 32'd0);
    // A lone stop bit leaves no payload
    load_stream('{8'h80});
    read_elem(CMD_MORE, 7'd0, 32'd0);
    read_elem(CMD_BITS, 7'd1, 32'd0);
    read_elem(CMD_BITS, 7'd1, 32'd0);
    drain_results();
  endtask

  // Long zero prefixes: Exp-Golomb overflow and saturating uvlc
  task automatic test_long_prefixes();
    load_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                  8'h80, 8'hFF});
    read_elem(CMD_UE, 7'd0, 32'd0);
    read_elem(CMD_SE, 7'd0, 32'd0);
    read_elem(CMD_UVLC, 7'd0, 32'd0);
    read_elem(CMD_MORE, 7'd0, 32'd0);
    load_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF,
                  8'hFF, 8'hFF, 8'hFF});
    read_elem(CMD_UE, 7'd0, 32'd0);
    load_stream('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    read_elem(CMD_UVLC, 7'd0, 32'd0);
    read_elem(CMD_LEB, 7'd0, 32'd0);
    drain_results();
  endtask

  // Emulation prevention bytes with the switch off and on
  task automatic test_emulation_bytes();
    set_epb(1'b0);
    load_stream('{8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h03, 8'h03, 8'hFF});
    read_elem(CMD_BITS, 7'd32, 32'd0);
    read_elem(CMD_BITS, 7'd32, 32'd0);
    read_elem(CMD_MORE, 7'd0, 32'd0);
    set_epb(1'b1);
    load_stream('{8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00, 8'h03, 8'h03, 8'hFF});
    read_elem(CMD_BITS, 7'd32, 32'd0);
    read_elem(CMD_BITS, 7'd16, 32'd0);
    read_elem(CMD_MORE, 7'd0, 32'd0);
    drain_results();
  endtask

  // Build a stream biased toward zeros, emulation bytes and stop bits
  function automatic void make_stream(ref logic [7:0] q [$]);
    int unsigned len;
    int unsigned r;
    q.delete();
    len = ($urandom_range(9) == 0) ? $urandom_range(25, 64) : $urandom_range(2, 24);
    while (q.size() < len) begin
      r = $urandom_range(99);
      if (r < 5) begin
        repeat ($urandom_range(4, 10)) q.push_back(8'h00);
      end else if (r < 25) q.push_back(8'h00);
      else if (r < 35) q.push_back(8'h03);
      else if (r < 43) q.push_back($urandom_range(1) ? 8'h80 : 8'h01);
      else if (r < 50) q.push_back(8'($urandom_range(15)));
      else q.push_back(8'($urandom));
    end
  endfunction

  // Pick the alphabet size of an ns request
  function automatic logic [31:0] pick_alphabet();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 4) return 32'd0;
    if (r < 45) return $urandom_range(1, 16);
    if (r < 60) return 32'd1 << $urandom_range(31);
    if (r < 65) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Streams followed by random reads, with a little noise mixed in
  task automatic test_random_traffic(int unsigned snd_pct, int unsigned rcv_pct,
                                     logic epb_start);
    logic [7:0]  stream [$];
    int unsigned start;
    int unsigned r;
    logic [3:0]  cmd;
    logic [6:0]  n;
    bit          held;
    send_gap_pct = snd_pct;
    recv_gap_pct = rcv_pct;
    held = 1'b0;
    for (int half = 0; half < 2; half++) begin
      set_epb((half == 0) ? epb_start : !epb_start);
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS / 2) begin
        make_stream(stream);
        load_stream(stream);
        repeat ($urandom_range(1, 10)) begin
          r = $urandom_range(99);
          if (r < 3) begin
            read_elem(4'($urandom_range(9, 15)), 7'($urandom), $urandom);
          end else if (r < 6) begin
            load_byte(8'($urandom), 1'b0);
          end else if (r < 7) begin
            load_byte(8'($urandom), 1'b1);
          end else begin
            cmd = 4'($urandom_range(1, 8));
            if (cmd == CMD_BITS || cmd == CMD_SU) begin
              r = $urandom_range(99);
              if (r < 8) n = 7'($urandom_range(65, 127));
              else if (r < 55) n = 7'($urandom_range(8));
              else n = 7'($urandom_range(64));
            end else begin
              n = 7'($urandom);
            end
            read_elem(cmd, n, (cmd == CMD_NS) ? pick_alphabet() : 32'($urandom));
          end
        end
        // Stall the receiver for a long stretch while requests keep coming
        if (!held && half == 0 && sent_items - start > PHASE_ITEMS / 4) begin
          stall_left = 400;
          held = 1'b1;
        end
      end
    end
  endtask

  // Timeout
  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    req_ch.valid         = 1'b0;
    req_ch.cmd           = CMD_LOAD;
    req_ch.data_byte     = 8'h00;
    req_ch.first_byte    = 1'b0;
    req_ch.bit_count_req = 7'd0;
    req_ch.max_value     = 32'd0;
    res_ch.ready         = 1'b0;
    mem_len              = 0;
    rd_byte              = 0;
    rd_bit               = 0;
    zeros_seen           = 0;
    bit_tally            = 0;
    epb_on               = 1'b1;
    mismatch_count       = 0;
    sent_items           = 0;
    stall_left           = 0;
    send_gap_pct         = 14;
    recv_gap_pct         = 56;
    foreach (byte_mem[i]) byte_mem[i] = 8'h00;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_command_set();
    test_long_prefixes();
    test_emulation_bytes();
    test_random_traffic(14, 56, 1'b0);
    test_random_traffic(56, 14, 1'b1);
    test_random_traffic(0, 0, 1'b0);
    drain_results();

    if (mismatch_count == 0 && expected_elems.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
